/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL that checks itself.
// Both macros vanish when the code is read for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define WPM_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("wpm assertion failed");

// Check that a condition never holds outside reset.
`define WPM_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("wpm condition must never hold");

`else

`define WPM_ASSERT_CLK(label, clk, rst_n, prop)
`define WPM_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* rtl/core/wpm_pkg.sv */
package wpm_pkg;

  // Pattern capacity and the widths derived from it
  localparam int MAX_PATTERN = 32;
  localparam int PAT_AW      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  // Fixed field widths
  localparam int SYM_W     = 8;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd3;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_STAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANY  = 2'd1;
  localparam logic [SYM_W-1:0] STAR_RESET = 8'd42;
  localparam logic [SYM_W-1:0] ANY_RESET  = 8'd63;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_BEGIN,
    OP_TEXT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
  } q_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic             sweeping;
    logic             ovf;
    logic [LEN_W-1:0] len;
  } bk_status_t;

endpackage

/* rtl/core/wpm_ram.sv */
module wpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/wpm_front.sv */
module wpm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wpm_pkg::CMD_W-1:0]   in_cmd,
  input  logic [wpm_pkg::SYM_W-1:0]   in_symbol,
  output logic                        q_valid,
  output wpm_pkg::q_item_t            q_item,
  input  logic                        q_pop
);
  import wpm_pkg::*;

  q_item_t               entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]   count_r, count_nxt;
  q_item_t               cls_item;
  logic                  push;
  logic                  pop;

  // Classify the incoming command
  always_comb begin
    cls_item.sym = in_symbol;
    unique case (in_cmd)
      CMD_CLEAR:  cls_item.op = OP_CLEAR;
      CMD_APPEND: cls_item.op = OP_APPEND;
      CMD_BEGIN:  cls_item.op = OP_BEGIN;
      CMD_TEXT:   cls_item.op = OP_TEXT;
    endcase
  end

  assign in_ready = (count_r != QUEUE_CW'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_item   = entries_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the accepted transaction
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

/* rtl/core/wpm_back.sv */
module wpm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  wpm_pkg::q_item_t            q_item,
  output logic                        q_pop,
  input  logic [wpm_pkg::SYM_W-1:0]   star_code,
  input  logic [wpm_pkg::SYM_W-1:0]   any_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_matched,
  output logic                        out_pattern_overflow,
  output wpm_pkg::bk_status_t         status
);
  import wpm_pkg::*;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [SYM_W-1:0]     sym_r, sym_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [MAX_PATTERN:0] row_r, row_nxt;
  logic [PAT_AW-1:0]    idx_r, idx_nxt;
  logic                 new_prev_r, new_prev_nxt;
  logic                 old_prev_r, old_prev_nxt;
  logic                 res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_matched_r, out_matched_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic                 ram_we;
  logic [PAT_AW-1:0]    ram_raddr;
  logic [SYM_W-1:0]     ram_rdata;
  logic [LEN_W-1:0]     col;
  logic                 old_here;
  logic                 is_star;
  logic                 is_one;
  logic                 nv;
  logic                 fin;
  logic                 fin_matched;
  logic                 out_free;

  // Pattern symbols
  wpm_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_PATTERN)
  ) u_pat_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[PAT_AW-1:0]),
    .wdata (q_item.sym),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Column of the sweep and the cell update
  assign col      = LEN_W'(idx_r) + LEN_W'(1);
  assign old_here = row_r[col];
  assign is_star  = (ram_rdata == star_code);
  assign is_one   = (ram_rdata == any_code) || (ram_rdata == sym_r);

  always_comb begin
    if (op_r == OP_BEGIN) begin
      nv = new_prev_r && is_star;
    end else if (is_star) begin
      nv = old_here || new_prev_r;
    end else if (is_one) begin
      nv = old_prev_r;
    end else begin
      nv = 1'b0;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign ram_we    = q_pop && (q_item.op == OP_APPEND) && (len_r != LEN_W'(MAX_PATTERN));
  assign ram_raddr = (state_r == ST_SWEEP) ? idx_r + 1'b1 : '0;

  // Sequence one transaction: decode, sweep the columns, hand off the result
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    sym_nxt         = sym_r;
    len_nxt         = len_r;
    ovf_nxt         = ovf_r;
    row_nxt         = row_r;
    idx_nxt         = idx_r;
    new_prev_nxt    = new_prev_r;
    old_prev_nxt    = old_prev_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_matched_nxt = out_matched_r;
    out_ovf_nxt     = out_ovf_r;
    fin             = 1'b0;
    fin_matched     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          op_nxt  = q_item.op;
          sym_nxt = q_item.sym;
          idx_nxt = '0;
          unique case (q_item.op)
            OP_CLEAR: begin
              len_nxt = '0;
              ovf_nxt = 1'b0;
              row_nxt = '0;
            end
            OP_APPEND: begin
              if (len_r != LEN_W'(MAX_PATTERN)) begin
                len_nxt = len_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
              row_nxt     = '0;
              fin         = 1'b1;
              fin_matched = 1'b0;
            end
            OP_BEGIN: begin
              row_nxt      = '0;
              row_nxt[0]   = 1'b1;
              new_prev_nxt = 1'b1;
              if (len_r == '0) begin
                fin         = 1'b1;
                fin_matched = 1'b1;
              end else begin
                state_nxt = ST_SWEEP;
              end
            end
            OP_TEXT: begin
              old_prev_nxt = row_r[0];
              row_nxt[0]   = 1'b0;
              new_prev_nxt = 1'b0;
              if (len_r == '0) begin
                fin         = 1'b1;
                fin_matched = 1'b0;
              end else begin
                state_nxt = ST_SWEEP;
              end
            end
          endcase
        end
      end
      ST_SWEEP: begin
        row_nxt[col] = nv;
        new_prev_nxt = nv;
        old_prev_nxt = old_here;
        if (col == len_r) begin
          fin         = 1'b1;
          fin_matched = nv;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_matched_nxt = res_r;
          out_ovf_nxt     = ovf_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Load the output register, or hold the result until it frees up
    if (fin) begin
      if (out_free) begin
        out_valid_nxt   = 1'b1;
        out_matched_nxt = fin_matched;
        out_ovf_nxt     = ovf_nxt;
        state_nxt       = ST_IDLE;
      end else begin
        res_nxt   = fin_matched;
        state_nxt = ST_RESULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and sweep working registers
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    sym_r         <= sym_nxt;
    idx_r         <= idx_nxt;
    new_prev_r    <= new_prev_nxt;
    old_prev_r    <= old_prev_nxt;
    res_r         <= res_nxt;
    out_matched_r <= out_matched_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

  assign status.sweeping = (state_r == ST_SWEEP);
  assign status.ovf      = ovf_r;
  assign status.len      = len_r;

endmodule

/* rtl/core/wildcard_pattern_matcher_core.sv */
// Wildcard pattern matcher. Load a pattern of up to 32 symbols with append
// transactions (cmd 1), then send a begin transaction (cmd 2) and one text
// transaction (cmd 3) per text symbol; each of these returns whether the text
// so far matches the whole pattern, together with the sticky overflow flag
// that reports a dropped pattern symbol. A clear (cmd 0) empties the pattern
// and returns nothing. The star and any codes are registers 0 and 1 of the
// configuration port (reset 42 and 63); the user must write them only while
// the block is idle, which the block itself does not enforce. The front end
// takes one transaction per cycle, while the queue has room, into a two-entry
// queue. The back end finishes clear and append when it decodes them, while
// begin and text then sweep one column per stored pattern symbol, because
// the match row advances one pattern column per cycle through the single read
// port of the pattern RAM. Each result waits for the output register to free up.
`include "assert_macros.svh"

module wildcard_pattern_matcher_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wpm_pkg::CMD_W-1:0]     in_cmd,
  input  logic [wpm_pkg::SYM_W-1:0]     in_symbol,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_matched,
  output logic                          out_pattern_overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wpm_pkg::SYM_W-1:0]     cfg_data
);
  import wpm_pkg::*;

  logic [SYM_W-1:0] star_code_r, star_code_nxt;
  logic [SYM_W-1:0] any_code_r, any_code_nxt;
  logic             q_valid;
  logic             q_pop;
  q_item_t          q_item;
  bk_status_t       bk_status;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    star_code_nxt = star_code_r;
    any_code_nxt  = any_code_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_STAR) begin
        star_code_nxt = cfg_data;
      end else if (cfg_index == CFG_ANY) begin
        any_code_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      star_code_r <= STAR_RESET;
      any_code_r  <= ANY_RESET;
    end else begin
      star_code_r <= star_code_nxt;
      any_code_r  <= any_code_nxt;
    end
  end

  wpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_symbol (in_symbol),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  wpm_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .star_code            (star_code_r),
    .any_code             (any_code_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_matched          (out_matched),
    .out_pattern_overflow (out_pattern_overflow),
    .status               (bk_status)
  );

  // Pattern length never passes capacity
  `WPM_ASSERT_NEVER(a_len_bound, clk, rst_n, bk_status.len > LEN_W'(MAX_PATTERN))
  // Back end pops only a queued transaction
  `WPM_ASSERT_CLK(a_pop_nonempty, clk, rst_n, q_pop |-> q_valid)
  // No new transaction starts during a sweep
  `WPM_ASSERT_CLK(a_no_pop_sweep, clk, rst_n, bk_status.sweeping |-> !q_pop)
  // Overflow is only ever flagged with a full pattern
  `WPM_ASSERT_CLK(a_ovf_full, clk, rst_n, bk_status.ovf |-> bk_status.len == LEN_W'(MAX_PATTERN))

endmodule
